// File: hdl/mse_pkg.sv
package mse_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  // Store address, element count (0..DEPTH) and run width (at most DEPTH).
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int WW     = CW + 1;
  localparam int SW     = CW + 2;

  typedef struct packed {
    logic load_en;
    logic sort_init;
    logic run_init;
    logic merge_wr;
    logic run_next;
    logic pass_next;
    logic emit_init;
    logic out_load;
    logic set_clear;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic sort_done;
    logic run_last;
    logic runs_done;
    logic out_fire;
    logic out_last;
  } status_t;

endpackage

// File: hdl/mse_if.sv
interface mse_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [mse_pkg::DATA_W-1:0]  value;
  logic                               last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink (input valid, input value, input last_in, output ready);
endinterface

interface mse_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mse_pkg::DATA_W-1:0]  sorted_value;
  logic                               last_out;
  logic                               overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input last_out, input overflow,
                output ready);
endinterface

// File: hdl/mse_ram.sv
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// File: hdl/mse_ctrl.sv
module mse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  mse_pkg::status_t st,
  output mse_pkg::cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_LOAD      = 7'b0000001,
    S_RUN       = 7'b0000010,
    S_RD        = 7'b0000100,
    S_MERGE     = 7'b0001000,
    S_EMIT_RD   = 7'b0010000,
    S_EMIT_OUT  = 7'b0100000,
    S_EMIT_WAIT = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        cmd.load_en = 1'b1;
        if (st.in_fire && st.in_last) begin
          cmd.sort_init = 1'b1;
          state_next    = S_RUN;
        end
      end
      S_RUN: begin
        if (st.sort_done) begin
          cmd.emit_init = 1'b1;
          state_next    = S_EMIT_RD;
        end else begin
          cmd.run_init = 1'b1;
          state_next   = S_RD;
        end
      end
      S_RD: begin
        state_next = S_MERGE;
      end
      S_MERGE: begin
        cmd.merge_wr = 1'b1;
        if (st.run_last) begin
          // The final run of a pass ends at the set size; then the width doubles.
          if (st.runs_done) begin
            cmd.pass_next = 1'b1;
          end else begin
            cmd.run_next = 1'b1;
          end
          state_next = S_RUN;
        end else begin
          state_next = S_RD;
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        cmd.out_load = 1'b1;
        state_next   = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (st.out_fire) begin
          if (st.out_last) begin
            cmd.set_clear = 1'b1;
            state_next    = S_LOAD;
          end else begin
            state_next = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

// File: hdl/mse_dp.sv
module mse_dp (
  input  logic             clk,
  input  logic             rst,
  mse_in_if.sink           elements,
  mse_out_if.source        sorted,
  input  mse_pkg::cmd_t    cmd,
  output mse_pkg::status_t st
);

  localparam int AW = mse_pkg::AW;
  localparam int CW = mse_pkg::CW;
  localparam int WW = mse_pkg::WW;
  localparam int SW = mse_pkg::SW;
  localparam int DW = mse_pkg::DATA_W;

  logic [CW-1:0] count;
  logic          dropped;
  logic [WW-1:0] w;
  logic [CW-1:0] lo;
  logic [CW-1:0] mid;
  logic [CW-1:0] hi;
  logic [CW-1:0] a;
  logic [CW-1:0] b;
  logic [CW-1:0] k;
  logic          sel;

  logic                 out_valid;
  logic signed [DW-1:0] out_value;
  logic                 out_last;
  logic                 out_ovf;

  logic                 in_fire;
  logic                 full;
  logic [SW-1:0]        n_ext;
  logic [SW-1:0]        mid_sum;
  logic [SW-1:0]        hi_sum;
  logic [CW-1:0]        mid_c;
  logic [CW-1:0]        hi_c;
  logic signed [DW-1:0] rd0_a;
  logic signed [DW-1:0] rd0_b;
  logic signed [DW-1:0] rd1_a;
  logic signed [DW-1:0] rd1_b;
  logic signed [DW-1:0] rd_a;
  logic signed [DW-1:0] rd_b;
  logic                 take_a;
  logic signed [DW-1:0] merged;
  logic                 we0;
  logic                 we1;
  logic [AW-1:0]        waddr;
  logic [DW-1:0]        wdata;

  assign elements.ready = cmd.load_en;
  assign in_fire        = elements.valid && cmd.load_en;
  assign full           = (count == CW'(mse_pkg::DEPTH));

  // Run bounds, clamped to the set size.
  assign n_ext   = SW'(count);
  assign mid_sum = SW'(lo) + SW'(w);
  assign hi_sum  = mid_sum + SW'(w);
  assign mid_c   = (mid_sum > n_ext) ? count : mid_sum[CW-1:0];
  assign hi_c    = (hi_sum > n_ext) ? count : hi_sum[CW-1:0];

  assign rd_a = sel ? rd1_a : rd0_a;
  assign rd_b = sel ? rd1_b : rd0_b;

  // Ties take the left run, which keeps the sort stable.
  assign take_a = (a < mid) && ((b >= hi) || (rd_a <= rd_b));
  assign merged = take_a ? rd_a : rd_b;

  // Loading always fills store 0; a merge pass writes the store it does not read.
  assign we0   = (in_fire && !full) || (cmd.merge_wr && sel);
  assign we1   = cmd.merge_wr && !sel;
  assign waddr = in_fire ? count[AW-1:0] : k[AW-1:0];
  assign wdata = in_fire ? elements.value : merged;

  mse_ram #(.WIDTH(DW), .DEPTH(mse_pkg::DEPTH)) u_ram0 (
    .clk    (clk),
    .we     (we0),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (a[AW-1:0]),
    .rdata0 (rd0_a),
    .raddr1 (b[AW-1:0]),
    .rdata1 (rd0_b)
  );

  mse_ram #(.WIDTH(DW), .DEPTH(mse_pkg::DEPTH)) u_ram1 (
    .clk    (clk),
    .we     (we1),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (a[AW-1:0]),
    .rdata0 (rd1_a),
    .raddr1 (b[AW-1:0]),
    .rdata1 (rd1_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (in_fire) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.set_clear) begin
        count   <= '0;
        dropped <= 1'b0;
      end
      if (cmd.sort_init) begin
        sel <= 1'b0;
      end else if (cmd.pass_next) begin
        sel <= ~sel;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (sorted.valid && sorted.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      w  <= WW'(1);
      lo <= '0;
    end else if (cmd.pass_next) begin
      w  <= {w[WW-2:0], 1'b0};
      lo <= '0;
    end else if (cmd.run_next) begin
      lo <= hi;
    end

    if (cmd.run_init) begin
      mid <= mid_c;
      hi  <= hi_c;
      a   <= lo;
      b   <= mid_c;
      k   <= lo;
    end else if (cmd.merge_wr) begin
      if (take_a) begin
        a <= a + CW'(1);
      end else begin
        b <= b + CW'(1);
      end
      k <= k + CW'(1);
    end else if (cmd.emit_init) begin
      a <= '0;
    end else if (cmd.out_load) begin
      a <= a + CW'(1);
    end

    if (cmd.out_load) begin
      out_value <= rd_a;
      out_last  <= (a + CW'(1) == count);
      out_ovf   <= dropped;
    end
  end

  assign sorted.valid        = out_valid;
  assign sorted.sorted_value = out_value;
  assign sorted.last_out     = out_last;
  assign sorted.overflow     = out_ovf;

  assign st.in_fire   = in_fire;
  assign st.in_last   = elements.last_in;
  assign st.sort_done = (w >= WW'(count));
  assign st.run_last  = (k + CW'(1) == hi);
  assign st.runs_done = (hi == count);
  assign st.out_fire  = sorted.valid && sorted.ready;
  assign st.out_last  = out_last;

endmodule

// File: hdl/merge_sort_engine.sv
// Stable ascending sort of a set of signed 32-bit values.
// The elements channel takes one value per item; the item with last_in set
// closes the set. Up to DEPTH (16) values are kept; further values, the
// closing one included, are dropped and overflow is set on every result.
// The sorted channel then delivers one result item per kept value in
// ascending order, equal values in arrival order, last_out on the final one.
// Loading takes one item per cycle. The sort is a bottom-up merge through
// two ping-pong RAMs with registered reads: each merged element is read,
// then compared and written, after a setup step for each run, over
// ceil(log2(n)) passes. Emitting reads each result, loads it into the
// output register and holds it there until it is taken, then reads the next.
// The elements channel is not ready from the closing item until the final
// result has been taken; a stall on the sorted channel holds the result and
// pauses the block. Reset empties the set and returns to loading at once.
module merge_sort_engine (
  input  logic      clk,
  input  logic      rst,
  mse_in_if.sink    elements,
  mse_out_if.source sorted
);

  mse_pkg::cmd_t    cmd;
  mse_pkg::status_t st;

  mse_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  mse_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .elements (elements),
    .sorted   (sorted),
    .cmd      (cmd),
    .st       (st)
  );

`ifndef ASSERT_OFF
  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(elements.ready && sorted.valid))
    else $error("input ready while a result is pending");

  // A set is not reopened before its final result has gone.
  a_hold_load: assert property (@(posedge clk) disable iff (rst)
    (sorted.valid && sorted.ready && !sorted.last_out) |=> !elements.ready)
    else $error("input reopened in the middle of a set");

  // Once the final result is taken the block loads again.
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (sorted.valid && sorted.ready && sorted.last_out) |=> elements.ready)
    else $error("input not reopened after the final result");
`endif

endmodule

// File: dv/merge_sort_engine_tb.sv
module merge_sort_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [mse_pkg::DATA_W-1:0] value;
    logic                              last;
    logic                              overflow;
  } sorted_item_t;

  // Keeps the set being loaded, sorts it when it closes and queues the expected results.
  class sort_scoreboard;
    logic signed [mse_pkg::DATA_W-1:0] open_set[$];
    bit                                dropped;
    sorted_item_t                      sorted_order[$];
    int                                errors;

    function new();
      dropped = 0;
      errors  = 0;
    endfunction

    function void note_element(logic signed [mse_pkg::DATA_W-1:0] v, logic l);
      logic signed [mse_pkg::DATA_W-1:0] key;
      sorted_item_t                      item;
      int                                j;
      if (open_set.size() < mse_pkg::DEPTH) begin
        open_set.push_back(v);
      end else begin
        dropped = 1;
      end
      if (!l) begin
        return;
      end
      // Insertion sort moves an element only past strictly greater ones, so ties keep
      // their arrival order.
      for (int i = 1; i < open_set.size(); i++) begin
        key = open_set[i];
        j = i - 1;
        while (j >= 0 && open_set[j] > key) begin
          open_set[j + 1] = open_set[j];
          j--;
        end
        open_set[j + 1] = key;
      end
      foreach (open_set[i]) begin
        item.value    = open_set[i];
        item.last     = (i == open_set.size() - 1);
        item.overflow = dropped;
        sorted_order.push_back(item);
      end
      open_set.delete();
      dropped = 0;
    endfunction

    function void check_result(logic signed [mse_pkg::DATA_W-1:0] v, logic l, logic o);
      sorted_item_t want;
      if (sorted_order.size() == 0) begin
        $display("%0t: result with none expected: value %0d last %0b overflow %0b",
                 $time, v, l, o);
        errors++;
        return;
      end
      want = sorted_order.pop_front();
      if (v !== want.value) begin
        $display("%0t: sorted_value expected %0d actual %0d", $time, want.value, v);
        errors++;
      end
      if (l !== want.last) begin
        $display("%0t: last_out expected %0b actual %0b", $time, want.last, l);
        errors++;
      end
      if (o !== want.overflow) begin
        $display("%0t: overflow expected %0b actual %0b", $time, want.overflow, o);
        errors++;
      end
    endfunction

    function int outstanding();
      return sorted_order.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  mse_in_if  elements ();
  mse_out_if sorted ();

  merge_sort_engine uut (
    .clk      (clk),
    .rst      (rst),
    .elements (elements),
    .sorted   (sorted)
  );

  sort_scoreboard board = new();

  int items_sent   = 0;
  int results_seen = 0;
  bit calm         = 0;

  always #6 clk = ~clk;

  // Mostly short gaps, now and then a long one; none while a calm stretch is running.
  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [mse_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 6)) - 3;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                            : 32'sh8000_0000 + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic send_element(logic signed [mse_pkg::DATA_W-1:0] v, logic l);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      elements.valid   = 1'b0;
      elements.value   = $urandom();
      elements.last_in = 1'($urandom_range(0, 1));
    end
    @(negedge clk);
    elements.valid   = 1'b1;
    elements.value   = v;
    elements.last_in = l;
    do @(posedge clk); while (!elements.ready);
    board.note_element(v, l);
    items_sent++;
  endtask

  task automatic send_set(int len);
    for (int i = 0; i < len; i++) begin
      send_element(pick_value(), i == len - 1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && sorted.valid && sorted.ready) begin
      board.check_result(sorted.sorted_value, sorted.last_out, sorted.overflow);
      results_seen++;
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up into its input.
  initial begin
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 0;
    sorted.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 60) begin
        hold_left = 400;
        hold_done = 1;
      end
      if (rst) begin
        sorted.ready = 1'b0;
      end else if (hold_left > 0) begin
        sorted.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        sorted.ready = 1'b0;
        stall_left--;
      end else begin
        sorted.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int len;
    rst              = 1'b1;
    elements.valid   = 1'b0;
    elements.value   = '0;
    elements.last_in = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A set of a single element.
    send_element(32'sh8000_0000, 1'b1);
    // Extremes of the value range, with a repeated maximum.
    send_element(32'sh7FFF_FFFF, 1'b0);
    send_element(-1, 1'b0);
    send_element(0, 1'b0);
    send_element(32'sh8000_0000, 1'b0);
    send_element(1, 1'b0);
    send_element(32'sh7FFF_FFFF, 1'b1);
    // A full store in falling order with pairs of equal values; the closing item is
    // dropped, so its minimum must not show up and every result carries overflow.
    for (int i = 0; i < mse_pkg::DEPTH; i++) begin
      send_element((7 - i / 2) * 1000003, 1'b0);
    end
    send_element(32'sh8000_0000, 1'b1);

    while (items_sent < 310) begin
      calm = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 19))
        0, 1:    len = mse_pkg::DEPTH;
        2, 3, 4: len = $urandom_range(mse_pkg::DEPTH + 1, mse_pkg::DEPTH + 8);
        default: len = $urandom_range(1, mse_pkg::DEPTH);
      endcase
      send_set(len);
    end
    calm = 0;
    @(negedge clk);
    elements.valid = 1'b0;

    while (board.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
